### sv/dmls_pkg.sv
package dmls_pkg;

  // Input item kinds, carried on tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Digits a 16-bit value can have
  localparam int unsigned NUM_DIG = 5;

  localparam logic [23:0] UNIT_RESET = 24'd480000;
  // Symbol index of the green marker after the five symbols of a digit
  localparam logic [2:0]  MARKER_POS = 3'd5;

  // Reciprocal multipliers: floor(v / 10^k) = (v * M) >> S, exact for v < 2^16
  localparam logic [32:0] DIV10_M    = 33'd52429;
  localparam logic [32:0] DIV100_M   = 33'd83887;
  localparam logic [32:0] DIV1000_M  = 33'd67109;
  localparam logic [32:0] DIV10000_M = 33'd107375;

  typedef logic [NUM_DIG-1:0][3:0] digit_vec_t;

  // Item as handed from the digit splitter to the sequencer
  typedef struct packed {
    logic       cmd;
    digit_vec_t digits;  // least significant digit at index 0
    logic [2:0] count;   // significant digits, 0 for a zero value
  } split_t;

  // Standard Morse numeral: 0 = five dashes, 1..5 = dots then dashes,
  // 6..9 = dashes then dots
  function automatic logic is_dash(logic [3:0] d, logic [2:0] k);
    logic r;
    if (d == 4'd0) begin
      r = 1'b1;
    end else if (d <= 4'd5) begin
      r = ({1'b0, k} >= d);
    end else begin
      r = ({1'b0, k} < (d - 4'd5));
    end
    return r;
  endfunction

endpackage

### sv/decimal_morse_led_sequencer_unit.sv
// Channel    Dir  Transfer                     Payload
// s_axis     in   s_axis_tvalid_i & tready_o   tuser[0] cmd, tdata[15:0] number_value
// m_axis     out  m_axis_tvalid_o & tready_i   tdata[0] red, [1] blue, [2] green, [3] busy
// cfg        in   cfg_we_i                     cfg_wdata_i[23:0] unit_ticks
//
// One item per clock while the result stream is not stalled; each item passes the
// three splitter stages (input, reciprocal multiplies, digit extraction) and then
// the sequencer's state and result register.
// Reset clears all control state and sets unit_ticks to 480000; no clearing pass.
// A stalled result holds in the output register; stages ahead keep filling
// their bubbles, so input transfers continue until every stage is full.
module decimal_morse_led_sequencer_unit #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,    // unit_ticks
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i, // [15:0] number_value
  input  logic        s_axis_tuser_i, // [0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o  // [0] red_dot_led, [1] blue_dash_led,
                                      // [2] green_gap_led, [3] busy_res, [7:4] zero
);
  import dmls_pkg::*;

  // splitter to sequencer transfer
  logic   split_valid;
  logic   split_ready;
  split_t split_item;
  logic [3:0] leds;

  // Split the number into decimal digits ahead of the sequencer; tick items
  // pass through the same stages so order is kept.
  dmls_digit_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .out_item_o  (split_item)
  );

  // Hold playback state, advance one tick per transfer, drop loads while busy.
  dmls_sequencer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_item_i   (split_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_leds_o  (leds)
  );

  assign m_axis_tdata_o = {4'd0, leds};

endmodule

### sv/dmls_digit_split.sv
module dmls_digit_split (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_cmd_i,
  input  logic [15:0]     in_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dmls_pkg::split_t out_item_o
);
  import dmls_pkg::*;

  // Stage 1: raw item
  logic        v1_q;
  logic        cmd1_q;
  logic [15:0] val1_q;
  // Stage 2: quotients by powers of ten
  logic        v2_q;
  logic        cmd2_q;
  logic [15:0] val2_q;
  logic [12:0] q1_q;
  logic [9:0]  q2_q;
  logic [6:0]  q3_q;
  logic [2:0]  q4_q;
  // Stage 3: digits
  logic        v3_q;
  split_t      item3_q, item3_d;

  logic rdy1, rdy2, rdy3;
  logic [32:0] p1, p2, p3, p4;
  logic [15:0] r0;
  logic [12:0] r1;
  logic [9:0]  r2;
  logic [6:0]  r3;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

  assign p1 = 33'(val1_q) * DIV10_M;
  assign p2 = 33'(val1_q) * DIV100_M;
  assign p3 = 33'(val1_q) * DIV1000_M;
  assign p4 = 33'(val1_q) * DIV10000_M;

  always_comb begin
    // remainder of each quotient against ten times the next one
    r0 = val2_q - 16'(q1_q) * 16'd10;
    r1 = q1_q - 13'(q2_q) * 13'd10;
    r2 = q2_q - 10'(q3_q) * 10'd10;
    r3 = q3_q - 7'(q4_q) * 7'd10;
    item3_d.cmd       = cmd2_q;
    item3_d.digits[0] = r0[3:0];
    item3_d.digits[1] = r1[3:0];
    item3_d.digits[2] = r2[3:0];
    item3_d.digits[3] = r3[3:0];
    item3_d.digits[4] = {1'b0, q4_q};
    if (q4_q != '0) begin
      item3_d.count = 3'd5;
    end else if (q3_q != '0) begin
      item3_d.count = 3'd4;
    end else if (q2_q != '0) begin
      item3_d.count = 3'd3;
    end else if (q1_q != '0) begin
      item3_d.count = 3'd2;
    end else if (val2_q != '0) begin
      item3_d.count = 3'd1;
    end else begin
      item3_d.count = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      cmd1_q <= in_cmd_i;
      val1_q <= in_value_i;
    end
    if (rdy2) begin
      cmd2_q <= cmd1_q;
      val2_q <= val1_q;
      q1_q   <= p1[31:19];
      q2_q   <= p2[32:23];
      q3_q   <= p3[32:26];
      q4_q   <= p4[32:30];
    end
    if (rdy3) begin
      item3_q <= item3_d;
    end
  end

endmodule

### sv/dmls_sequencer.sv
module dmls_sequencer #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [23:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dmls_pkg::split_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       out_leds_o
);
  import dmls_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LIT,
    PH_DARK
  } phase_e;

  typedef logic [MAX_DIGITS-1:0][3:0] store_t;

  logic [23:0] unit_q;
  store_t      digit_store_q, digit_store_d;
  logic [2:0]  digit_total_q, digit_total_d;
  logic [2:0]  digit_pos_q, digit_pos_d;
  logic [2:0]  symbol_pos_q, symbol_pos_d;
  phase_e      phase_q, phase_d;
  logic [24:0] tick_left_q, tick_left_d;
  logic        out_valid_q;
  logic [3:0]  leds_q, leds_d;

  logic        take;
  logic [24:0] u1, u2, tl_dec;
  logic [2:0]  n_load, sym_nxt, pos_nxt;
  logic [3:0]  first_dig;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_leds_o  = leds_q;

  assign u1      = (unit_q == '0) ? 25'd1 : {1'b0, unit_q};
  assign u2      = {u1[23:0], 1'b0};
  assign tl_dec  = (tick_left_q != '0) ? tick_left_q - 25'd1 : '0;
  assign n_load  = (in_item_i.count > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : in_item_i.count;
  assign first_dig = (n_load != '0) ? in_item_i.digits[n_load - 3'd1] : 4'd0;
  assign sym_nxt = symbol_pos_q + 3'd1;
  assign pos_nxt = digit_pos_q + 3'd1;

  always_comb begin
    digit_store_d = digit_store_q;
    digit_total_d = digit_total_q;
    digit_pos_d   = digit_pos_q;
    symbol_pos_d  = symbol_pos_q;
    phase_d       = phase_q;
    tick_left_d   = tick_left_q;
    leds_d        = 4'd0;  // {busy, green, blue, red}
    if (in_item_i.cmd == CMD_LOAD) begin
      if (phase_q == PH_IDLE) begin
        if (n_load != '0) begin
          // store in play order: most significant kept digit at the head
          for (int i = 0; i < int'(MAX_DIGITS); i++) begin
            if (3'(i) < n_load) begin
              digit_store_d[i] = in_item_i.digits[n_load - 3'd1 - 3'(i)];
            end else begin
              digit_store_d[i] = 4'd0;
            end
          end
          digit_total_d = n_load;
          digit_pos_d   = '0;
          symbol_pos_d  = '0;
          phase_d       = PH_LIT;
          tick_left_d   = is_dash(first_dig, 3'd0) ? u2 : u1;
          leds_d[3]     = 1'b1;
        end
      end else begin
        leds_d[3] = 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      leds_d[3] = 1'b1;
      if (phase_q == PH_LIT) begin
        if (symbol_pos_q >= MARKER_POS) begin
          leds_d[2] = 1'b1;
        end else if (is_dash(digit_store_q[0], symbol_pos_q)) begin
          leds_d[1] = 1'b1;
        end else begin
          leds_d[0] = 1'b1;
        end
      end
      tick_left_d = tl_dec;
      if (tl_dec == '0) begin
        case (phase_q)
          PH_LIT: begin
            phase_d     = PH_DARK;
            tick_left_d = (symbol_pos_q >= MARKER_POS) ? u2 : u1;
          end
          PH_DARK: begin
            if (symbol_pos_q < MARKER_POS) begin
              // next symbol of the same digit, or the green marker
              symbol_pos_d = sym_nxt;
              phase_d      = PH_LIT;
              if (sym_nxt >= MARKER_POS || is_dash(digit_store_q[0], sym_nxt)) begin
                tick_left_d = u2;
              end else begin
                tick_left_d = u1;
              end
            end else if (pos_nxt < digit_total_q) begin
              // shift the next digit to the head
              digit_store_d = digit_store_q >> 4;
              digit_pos_d  = pos_nxt;
              symbol_pos_d = '0;
              phase_d      = PH_LIT;
              tick_left_d  = is_dash(digit_store_q[1], 3'd0) ? u2 : u1;
            end else begin
              phase_d       = PH_IDLE;
              digit_total_d = '0;
              digit_pos_d   = '0;
              symbol_pos_d  = '0;
              tick_left_d   = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q        <= UNIT_RESET;
      digit_store_q <= '0;
      digit_total_q <= '0;
      digit_pos_q   <= '0;
      symbol_pos_q  <= '0;
      phase_q       <= PH_IDLE;
      tick_left_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      if (take) begin
        digit_store_q <= digit_store_d;
        digit_total_q <= digit_total_d;
        digit_pos_q   <= digit_pos_d;
        symbol_pos_q  <= symbol_pos_d;
        phase_q       <= phase_d;
        tick_left_q   <= tick_left_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      leds_q <= leds_d;
    end
  end

endmodule
